// File: design/rbsi_pkg.sv
package rbsi_pkg;

    // Input transfer: one ray, signed Q16.16.
    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray_in;

    // Result transfer.
    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_distance;
        logic [2:0]         hit_face;
        logic signed [31:0] hit_point_x;
        logic signed [31:0] hit_point_y;
        logic signed [31:0] hit_point_z;
    } t_ray_out;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] CFG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] CFG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] CFG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] CFG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] CFG_BOX_MAX_Z = 3'd5;
    localparam logic [2:0] CFG_MIN_DIST  = 3'd6;

    localparam logic signed [31:0] BOX_MIN_RST  = -32'sd65536;
    localparam logic signed [31:0] BOX_MAX_RST  = 32'sd65536;
    localparam logic [16:0]        MIN_DIST_RST = 17'd7;

    // Distances carry two extra bits so that the unbounded slab (+/- 2^32) fits.
    localparam logic signed [33:0] T_UNBOUNDED = 34'sh1_0000_0000;
    localparam logic signed [33:0] T_SAT_MAX   = 34'sh0_7FFF_FFFF;
    localparam logic signed [33:0] T_SAT_MIN   = -34'sh0_8000_0000;

    localparam int DIV_STAGES = 32;

    // One lane of the pipelined restoring divider.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] den;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } t_div_lane;

    typedef struct packed {
        logic signed [31:0] o_x;
        logic signed [31:0] o_y;
        logic signed [31:0] o_z;
        logic signed [31:0] d_x;
        logic signed [31:0] d_y;
        logic signed [31:0] d_z;
        logic               miss;
    } t_ray_ctx;

    function automatic t_div_lane div_step(input t_div_lane a);
        t_div_lane   r;
        logic [32:0] trial;
        r = a;
        trial = {a.rem, a.low[31]};
        if (trial >= {1'b0, a.den}) begin
            r.rem = 32'(trial - {1'b0, a.den});
            r.quo = {a.quo[30:0], 1'b1};
        end else begin
            r.rem = trial[31:0];
            r.quo = {a.quo[30:0], 1'b0};
        end
        r.low = {a.low[30:0], 1'b0};
        return r;
    endfunction

    // Signed, saturated slab distance from a finished divider lane.
    function automatic logic signed [33:0] div_result(input t_div_lane a);
        logic signed [33:0] t;
        if (!a.neg) begin
            if (a.ovf || a.quo[31]) t = T_SAT_MAX;
            else                    t = $signed({2'b00, a.quo});
        end else begin
            if (a.ovf || a.quo > 32'h8000_0000) t = T_SAT_MIN;
            else                                t = 34'sd0 - $signed({2'b00, a.quo});
        end
        return t;
    endfunction

endpackage

// File: design/ray_box_slab_intersect.sv
// Ray against axis-aligned box, slab method.
//
// A ray is transferred in on i_ray when start is high and busy is low. busy
// is always low: the block takes a new ray in every cycle. Each ray gives
// exactly one result transfer on o_result, marked by o_valid for a single
// cycle, at the end of the pipeline. The receiver cannot hold results off,
// and none is needed: rays stream through a fixed pipeline. Throughput is
// one ray per cycle. The pipe holds the six-lane divider, which resolves one
// quotient bit per stage over 32 stages, plus eight stages for operand
// setup, slab selection, the hit decision, the hit point multiply and its
// saturating add.
//
// The box corners and epsilon are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; writes are taken at once and must only happen while no ray
// is in flight. Unknown indexes are ignored.
// Reset clears all valid bits, so nothing in flight produces a result, and
// restores the box to [-1,1] on every axis and the epsilon to 7.
module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_ray_in     i_ray,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output t_ray_out    o_result
);

    localparam int NCTX = DIV_STAGES + 6;
    localparam int LAT  = DIV_STAGES + 8;

    // Configuration registers.
    logic signed [31:0] r_lo [3];
    logic signed [31:0] r_hi [3];
    logic [16:0]        r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_lo[k] <= BOX_MIN_RST;
                r_hi[k] <= BOX_MAX_RST;
            end
            r_eps <= MIN_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BOX_MIN_X: r_lo[0] <= i_cfg_data;
                CFG_BOX_MIN_Y: r_lo[1] <= i_cfg_data;
                CFG_BOX_MIN_Z: r_lo[2] <= i_cfg_data;
                CFG_BOX_MAX_X: r_hi[0] <= i_cfg_data;
                CFG_BOX_MAX_Y: r_hi[1] <= i_cfg_data;
                CFG_BOX_MAX_Z: r_hi[2] <= i_cfg_data;
                CFG_MIN_DIST:  r_eps   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 0: input register.
    logic    r_v0;
    t_ray_in r_ray;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= start && !busy;
        r_ray <= i_ray;
    end

    // Stage 1: slab corner differences, magnitudes and signs.
    // Lane k is the entry plane of axis k, lane k+3 its exit plane.
    logic signed [31:0] w_o [3];
    logic signed [31:0] w_d [3];
    assign w_o[0] = r_ray.origin_x;
    assign w_o[1] = r_ray.origin_y;
    assign w_o[2] = r_ray.origin_z;
    assign w_d[0] = r_ray.dir_x;
    assign w_d[1] = r_ray.dir_y;
    assign w_d[2] = r_ray.dir_z;

    logic [32:0]  n_mag [6];
    logic [31:0]  n_den [6];
    logic         n_neg [6];
    logic         n_miss;

    always_comb begin
        logic signed [31:0] corner;
        logic signed [32:0] diff;
        n_miss = 1'b0;
        for (int j = 0; j < 6; j++) begin
            n_mag[j] = '0;
            n_den[j] = '0;
            n_neg[j] = 1'b0;
        end
        for (int k = 0; k < 3; k++) begin
            if (w_d[k] == 32'sd0 && (w_o[k] < r_lo[k] || w_o[k] > r_hi[k]))
                n_miss = 1'b1;
            for (int e = 0; e < 2; e++) begin
                // A negative direction swaps which corner is entered first.
                if ((e == 0) != w_d[k][31]) corner = r_lo[k];
                else                        corner = r_hi[k];
                diff = 33'(corner) - 33'(w_o[k]);
                n_mag[k + 3 * e] = diff[32] ? 33'(-diff) : 33'(diff);
                n_den[k + 3 * e] = w_d[k][31] ? 32'(-w_d[k]) : 32'(w_d[k]);
                n_neg[k + 3 * e] = diff[32] ^ w_d[k][31];
            end
        end
    end

    logic        r_v1;
    logic [32:0] r_mag [6];
    logic [31:0] r_den [6];
    logic        r_neg [6];
    t_ray_ctx    r_ctx [NCTX];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= r_v0;
        for (int j = 0; j < 6; j++) begin
            r_mag[j] <= n_mag[j];
            r_den[j] <= n_den[j];
            r_neg[j] <= n_neg[j];
        end
        r_ctx[0] <= '{o_x: w_o[0], o_y: w_o[1], o_z: w_o[2],
                      d_x: w_d[0], d_y: w_d[1], d_z: w_d[2], miss: n_miss};
        for (int s = 1; s < NCTX; s++) r_ctx[s] <= r_ctx[s - 1];
    end

    // Stage 2: divider setup. The quotient (mag * 2^16) / den saturates
    // whenever it reaches 2^32, which a single compare detects.
    // Stages 3 .. 34: one quotient bit per stage.
    logic      r_dv  [DIV_STAGES + 1];
    t_div_lane r_div [DIV_STAGES + 1][6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) r_dv[s] <= 1'b0;
        end else begin
            r_dv[0] <= r_v1;
            for (int s = 1; s <= DIV_STAGES; s++) r_dv[s] <= r_dv[s - 1];
        end
        for (int j = 0; j < 6; j++) begin
            r_div[0][j].rem <= {15'd0, r_mag[j][32:16]};
            r_div[0][j].low <= {r_mag[j][15:0], 16'd0};
            r_div[0][j].den <= r_den[j];
            r_div[0][j].quo <= '0;
            r_div[0][j].neg <= r_neg[j];
            r_div[0][j].ovf <= {15'd0, r_mag[j]} >= {r_den[j], 16'd0};
            for (int s = 1; s <= DIV_STAGES; s++)
                r_div[s][j] <= div_step(r_div[s - 1][j]);
        end
    end

    // Stage 35: signed saturated slab distances, unbounded for zero direction.
    t_ray_ctx w_c3;
    assign w_c3 = r_ctx[DIV_STAGES + 1];

    logic signed [31:0] w_d3 [3];
    assign w_d3[0] = w_c3.d_x;
    assign w_d3[1] = w_c3.d_y;
    assign w_d3[2] = w_c3.d_z;

    logic               r_v3;
    logic signed [33:0] r_tin  [3];
    logic signed [33:0] r_tout [3];
    logic [2:0]         r_fin  [3];
    logic [2:0]         r_fout [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_dv[DIV_STAGES];
        for (int k = 0; k < 3; k++) begin
            if (w_d3[k] == 32'sd0) begin
                r_tin[k]  <= -T_UNBOUNDED;
                r_tout[k] <= T_UNBOUNDED;
            end else begin
                r_tin[k]  <= div_result(r_div[DIV_STAGES][k]);
                r_tout[k] <= div_result(r_div[DIV_STAGES][k + 3]);
            end
            // A zero component counts as positive for the face choice.
            r_fin[k]  <= w_d3[k][31] ? 3'(k + 3) : 3'(k);
            r_fout[k] <= w_d3[k][31] ? 3'(k) : 3'(k + 3);
        end
    end

    // Stage 36: latest entry and earliest exit. Ties between x and y go to
    // y; z wins only when strictly better.
    logic signed [33:0] n_t0, n_t1;
    logic [2:0]         n_f0, n_f1;
    always_comb begin
        if (r_tin[0] > r_tin[1]) begin
            n_t0 = r_tin[0]; n_f0 = r_fin[0];
        end else begin
            n_t0 = r_tin[1]; n_f0 = r_fin[1];
        end
        if (r_tin[2] > n_t0) begin
            n_t0 = r_tin[2]; n_f0 = r_fin[2];
        end
        if (r_tout[0] < r_tout[1]) begin
            n_t1 = r_tout[0]; n_f1 = r_fout[0];
        end else begin
            n_t1 = r_tout[1]; n_f1 = r_fout[1];
        end
        if (r_tout[2] < n_t1) begin
            n_t1 = r_tout[2]; n_f1 = r_fout[2];
        end
    end

    logic               r_v4;
    logic signed [33:0] r_t0, r_t1;
    logic [2:0]         r_f0, r_f1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3;
        r_t0 <= n_t0;
        r_t1 <= n_t1;
        r_f0 <= n_f0;
        r_f1 <= n_f1;
    end

    // Stage 37: hit decision, chosen distance and face.
    t_ray_ctx w_c4;
    assign w_c4 = r_ctx[DIV_STAGES + 3];

    logic signed [33:0] w_eps;
    logic signed [33:0] w_t;
    logic               n_hit;
    assign w_eps = $signed({17'd0, r_eps});
    assign n_hit = !w_c4.miss && (r_t0 < r_t1) && (r_t1 > w_eps);
    assign w_t   = (r_t0 > w_eps) ? r_t0 : r_t1;

    logic               r_v5;
    logic               r_hit5;
    logic signed [31:0] r_ts5;
    logic [2:0]         r_face5;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
        r_hit5  <= n_hit;
        r_face5 <= (r_t0 > w_eps) ? r_f0 : r_f1;
        if (w_t > T_SAT_MAX)      r_ts5 <= T_SAT_MAX[31:0];
        else if (w_t < T_SAT_MIN) r_ts5 <= T_SAT_MIN[31:0];
        else                      r_ts5 <= w_t[31:0];
    end

    // Stage 38: direction times distance, exact 64-bit products.
    t_ray_ctx w_c5;
    assign w_c5 = r_ctx[DIV_STAGES + 4];

    logic               r_v6;
    logic               r_hit6;
    logic signed [31:0] r_ts6;
    logic [2:0]         r_face6;
    logic signed [63:0] r_prod [3];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v6 <= 1'b0;
        else          r_v6 <= r_v5;
        r_hit6    <= r_hit5;
        r_ts6     <= r_ts5;
        r_face6   <= r_face5;
        r_prod[0] <= w_c5.d_x * r_ts5;
        r_prod[1] <= w_c5.d_y * r_ts5;
        r_prod[2] <= w_c5.d_z * r_ts5;
    end

    // Stage 39: floor to Q16.16 (arithmetic shift), add origin, saturate.
    t_ray_ctx w_c6;
    assign w_c6 = r_ctx[DIV_STAGES + 5];

    logic signed [31:0] w_o6 [3];
    assign w_o6[0] = w_c6.o_x;
    assign w_o6[1] = w_c6.o_y;
    assign w_o6[2] = w_c6.o_z;

    logic signed [31:0] n_pt [3];
    always_comb begin
        logic signed [48:0] p;
        for (int k = 0; k < 3; k++) begin
            p = 49'(w_o6[k]) + 49'($signed(r_prod[k][63:16]));
            if (p > 49'sh0_7FFF_FFFF)       n_pt[k] = 32'sh7FFF_FFFF;
            else if (p < -49'sh0_8000_0000) n_pt[k] = 32'sh8000_0000;
            else                            n_pt[k] = p[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_v6;
        if (r_hit6) begin
            o_result <= '{hit: 1'b1, hit_distance: r_ts6, hit_face: r_face6,
                          hit_point_x: n_pt[0], hit_point_y: n_pt[1],
                          hit_point_z: n_pt[2]};
        end else begin
            o_result <= '0;
        end
    end

    // Every accepted ray produces its result after the fixed latency.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("result missing after pipeline latency");

    // A miss reports all-zero fields.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.hit) |->
            (o_result.hit_distance == 32'sd0 && o_result.hit_face == 3'd0 &&
             o_result.hit_point_x == 32'sd0 && o_result.hit_point_y == 32'sd0 &&
             o_result.hit_point_z == 32'sd0))
        else $error("miss with nonzero fields");

    // A hit lies beyond the epsilon on a real face.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.hit) |->
            (o_result.hit_distance > $signed({15'd0, r_eps}) &&
             o_result.hit_face <= 3'd5))
        else $error("hit distance or face out of range");

endmodule

// File: bench/ray_box_checker.sv
module ray_box_checker
    import rbsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_ray_in     i_ray,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  t_ray_out    i_result,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint UNB = 64'sd4294967296;

    longint box_lo [3];
    longint box_hi [3];
    longint eps;
    t_ray_out expected_hits [$];

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_q16(input longint x);
        if (x >= 0) return x >>> 16;
        return -(((-x) + 65535) >>> 16);
    endfunction

    function automatic t_ray_out trace_ray(input t_ray_in r);
        t_ray_out res;
        longint o [3];
        longint d [3];
        longint tin [3];
        longint tout [3];
        int fin [3];
        int fout [3];
        longint t0, t1, t;
        int face_in, face_out, face;
        bit miss;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
        miss = 0;
        for (int k = 0; k < 3; k++) begin
            if (d[k] == 0) begin
                if (o[k] < box_lo[k] || o[k] > box_hi[k]) miss = 1;
                tin[k] = -UNB; tout[k] = UNB; fin[k] = k; fout[k] = k + 3;
            end else if (d[k] > 0) begin
                tin[k]  = sat32(((box_lo[k] - o[k]) * 65536) / d[k]);
                tout[k] = sat32(((box_hi[k] - o[k]) * 65536) / d[k]);
                fin[k] = k; fout[k] = k + 3;
            end else begin
                tin[k]  = sat32(((box_hi[k] - o[k]) * 65536) / d[k]);
                tout[k] = sat32(((box_lo[k] - o[k]) * 65536) / d[k]);
                fin[k] = k + 3; fout[k] = k;
            end
        end
        if (tin[0] > tin[1]) begin t0 = tin[0]; face_in = fin[0]; end
        else begin t0 = tin[1]; face_in = fin[1]; end
        if (tin[2] > t0) begin t0 = tin[2]; face_in = fin[2]; end
        if (tout[0] < tout[1]) begin t1 = tout[0]; face_out = fout[0]; end
        else begin t1 = tout[1]; face_out = fout[1]; end
        if (tout[2] < t1) begin t1 = tout[2]; face_out = fout[2]; end
        res = '0;
        if (miss || !(t0 < t1) || !(t1 > eps)) return res;
        if (t0 > eps) begin t = t0; face = face_in; end
        else begin t = t1; face = face_out; end
        t = sat32(t);
        res.hit = 1'b1;
        res.hit_distance = t[31:0];
        res.hit_face = face[2:0];
        res.hit_point_x = 32'(sat32(o[0] + floor_q16(d[0] * t)));
        res.hit_point_y = 32'(sat32(o[1] + floor_q16(d[1] * t)));
        res.hit_point_z = 32'(sat32(o[2] + floor_q16(d[2] * t)));
        return res;
    endfunction

    assign o_pending = expected_hits.size();

    always @(posedge i_clk) begin
        t_ray_out want;
        if (!i_rst_n) begin
            box_lo = '{BOX_MIN_RST, BOX_MIN_RST, BOX_MIN_RST};
            box_hi = '{BOX_MAX_RST, BOX_MAX_RST, BOX_MAX_RST};
            eps = MIN_DIST_RST;
            expected_hits.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BOX_MIN_X: box_lo[0] = $signed(i_cfg_data);
                    CFG_BOX_MIN_Y: box_lo[1] = $signed(i_cfg_data);
                    CFG_BOX_MIN_Z: box_lo[2] = $signed(i_cfg_data);
                    CFG_BOX_MAX_X: box_hi[0] = $signed(i_cfg_data);
                    CFG_BOX_MAX_Y: box_hi[1] = $signed(i_cfg_data);
                    CFG_BOX_MAX_Z: box_hi[2] = $signed(i_cfg_data);
                    CFG_MIN_DIST:  eps = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (expected_hits.size() == 0) begin
                    $error("result with nothing expected");
                    o_errors++;
                end else begin
                    want = expected_hits.pop_front();
                    if (i_result.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_result.hit);
                        o_errors++;
                    end
                    if (i_result.hit_distance !== want.hit_distance) begin
                        $error("hit_distance: expected %0d, got %0d",
                               want.hit_distance, i_result.hit_distance);
                        o_errors++;
                    end
                    if (i_result.hit_face !== want.hit_face) begin
                        $error("hit_face: expected %0d, got %0d",
                               want.hit_face, i_result.hit_face);
                        o_errors++;
                    end
                    if (i_result.hit_point_x !== want.hit_point_x) begin
                        $error("hit_point_x: expected %0d, got %0d",
                               want.hit_point_x, i_result.hit_point_x);
                        o_errors++;
                    end
                    if (i_result.hit_point_y !== want.hit_point_y) begin
                        $error("hit_point_y: expected %0d, got %0d",
                               want.hit_point_y, i_result.hit_point_y);
                        o_errors++;
                    end
                    if (i_result.hit_point_z !== want.hit_point_z) begin
                        $error("hit_point_z: expected %0d, got %0d",
                               want.hit_point_z, i_result.hit_point_z);
                        o_errors++;
                    end
                end
            end
            // Prediction is taken after any config write of the same edge,
            // though the bench never mixes the two.
            if (i_start && !i_busy) expected_hits.push_back(trace_ray(i_ray));
        end
    end

endmodule

// File: bench/tb_ray_box_slab_intersect.sv
module tb_ray_box_slab_intersect;
    timeunit 1ns;
    timeprecision 1ps;
    import rbsi_pkg::*;

    // Pipeline depth; the final wait allows a generous margin beyond it.
    localparam int LATENCY = 40;
    localparam int WATCHDOG = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_ray_in     i_ray;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    t_ray_out    o_result;
    int          fail_count;
    int          in_flight;
    int          idle_cycles;

    ray_box_slab_intersect uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_ray(i_ray), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_result(o_result)
    );

    ray_box_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_ray(i_ray), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(o_valid), .i_result(o_result),
        .o_errors(fail_count), .o_pending(in_flight)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The watchdog counts cycles with no transfer in either direction. It
    // is reset by every accepted ray and every result.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("ray_box_slab_intersect regression: fail");
            $finish;
        end
    end

    // Presents one ray from the falling edge and holds it until accepted.
    // start stays high when the next ray follows at once, so no edge ever
    // sees it lowered and raised again.
    task automatic send_ray(input t_ray_in r, input bit keep_start);
        i_ray <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (!keep_start) start <= 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Registers may only change with the pipe empty; every ray yields a
    // result, so an empty expectation queue means the pipe has drained.
    task automatic drain();
        while (in_flight != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic load_box(input logic [31:0] lx, input logic [31:0] ly,
                            input logic [31:0] lz, input logic [31:0] hx,
                            input logic [31:0] hy, input logic [31:0] hz,
                            input logic [31:0] eps);
        drain();
        write_reg(CFG_BOX_MIN_X, lx);
        write_reg(CFG_BOX_MIN_Y, ly);
        write_reg(CFG_BOX_MIN_Z, lz);
        write_reg(CFG_BOX_MAX_X, hx);
        write_reg(CFG_BOX_MAX_Y, hy);
        write_reg(CFG_BOX_MAX_Z, hz);
        write_reg(CFG_MIN_DIST, eps);
    endtask

    function automatic t_ray_in mk(input int ox, input int oy, input int oz,
                                   input int dx, input int dy, input int dz);
        t_ray_in r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
        return r;
    endfunction

    // A component that is mostly near the box scale, sometimes small,
    // sometimes zero, and sometimes any 32-bit value at all.
    function automatic logic [31:0] rand_comp(input int scale);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:       return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 2 * scale)) - scale);
        endcase
    endfunction

    // A burst of random rays, mostly aimed near the box: the origin is
    // placed outside or inside and the direction points roughly back at the
    // center, so that many rays actually hit.
    task automatic random_rays(input int count, input int scale);
        t_ray_in r;
        int burst;
        burst = 0;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) != 0) begin
                r.origin_x = rand_comp(4 * scale);
                r.origin_y = rand_comp(4 * scale);
                r.origin_z = rand_comp(4 * scale);
                r.dir_x = 32'(-$signed(r.origin_x) / 4) + rand_comp(scale / 2);
                r.dir_y = 32'(-$signed(r.origin_y) / 4) + rand_comp(scale / 2);
                r.dir_z = 32'(-$signed(r.origin_z) / 4) + rand_comp(scale / 2);
            end else begin
                r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom()};
            end
            if (burst == 0) begin
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
                burst = $urandom_range(1, 20);
            end
            burst--;
            send_ray(r, burst != 0 && n != count - 1);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_ray = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_BOX_MIN_X;
        i_cfg_data = '0;
        idle_cycles = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed rays against the reset box [-1,1]^3 with epsilon 7.
        send_ray(mk(-196608, 0, 0, 65536, 0, 0), 1);        // straight in on -x
        send_ray(mk(0, 196608, 0, 0, -65536, 0), 1);        // straight in on +y
        send_ray(mk(0, 0, 0, 0, 0, 0), 1);                  // zero direction, inside
        send_ray(mk(196608, 0, 0, 0, 0, 0), 1);             // zero direction, outside
        send_ray(mk(0, 0, 0, 0, 0, 65536), 1);              // origin inside, exit face
        send_ray(mk(-196608, -196608, 0, 65536, 65536, 0), 1); // x/y entry tie
        send_ray(mk(-196608, -196608, -196608, 65536, 65536, 65536), 1);
        send_ray(mk(196608, 0, 0, 65536, 0, 0), 1);         // pointing away
        send_ray(mk(65536, 0, 0, 65536, 0, 0), 1);          // exit at zero distance
        send_ray(mk(32'h8000_0000, 0, 0, 1, 0, 0), 1);      // saturated slab distance
        send_ray(mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000), 1);
        send_ray(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1);
        send_ray(mk(-131072, 1, -1, 1, 0, 0), 0);           // tiny direction
        // Pause the sender until every expected result is back.
        drain();

        // Epsilon larger than one, and the zero epsilon.
        load_box(-65536, -65536, -65536, 65536, 65536, 65536, 32'h1_FFFF);
        send_ray(mk(-196608, 0, 0, 65536, 0, 0), 1);
        send_ray(mk(0, 0, 0, 65536, 0, 0), 0);
        load_box(-65536, -65536, -65536, 65536, 65536, 65536, 0);
        send_ray(mk(65536, 0, 0, 65536, 0, 0), 1);
        send_ray(mk(0, 0, 0, 0, 0, 0), 0);
        // Inverted box, then the full-range box.
        load_box(65536, 0, 0, -65536, 0, 0, 7);
        send_ray(mk(0, 0, 0, 65536, 65536, 65536), 0);
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1_0000);
        send_ray(mk(0, 0, 0, 1, -1, 1), 1);
        send_ray(mk(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0), 0);

        // Random phases with several boxes, including the extremes.
        load_box(-65536, -65536, -65536, 65536, 65536, 65536, 7);
        random_rays(120, 65536);
        load_box($urandom_range(0, 65536) - 262144, -32768, 32'h8000_0000,
                 $urandom_range(0, 262144), 98304, 32768, $urandom_range(0, 200));
        random_rays(100, 262144);
        load_box($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom());
        random_rays(60, 32'h4000_0000);
        load_box(32'h8000_0000, -6553600, -1, 32'h7FFF_FFFF, 6553600, 1,
                 $urandom_range(0, 65536));
        random_rays(100, 6553600);
        load_box(-10, -10, -10, 10, 10, 10, 0);
        random_rays(70, 64);

        drain();
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0 && in_flight == 0) begin
            $display("ray_box_slab_intersect regression: pass");
        end else begin
            $display("ray_box_slab_intersect regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
design/rbsi_pkg.sv
design/ray_box_slab_intersect.sv
bench/ray_box_checker.sv
bench/tb_ray_box_slab_intersect.sv
